### hdl/mlpci_pkg.sv
// ----------------------------------------------------------------------------
// mlpci_pkg
// Shared types, constants and helpers of the two-layer perceptron classifier.
// ----------------------------------------------------------------------------
package mlpci_pkg;

	// Default sizes of the network
	localparam int IN_DIM_DEF       = 12;
	localparam int HID_DIM_DEF      = 7;
	localparam int OUT_DIM_DEF      = 2;
	localparam int WEIGHT_DEPTH_DEF = 128;

	// Field widths
	localparam int WIDX_W  = 7;
	localparam int VAL_W   = 16;
	localparam int DIST_W  = 24;
	localparam int NCLS_W  = 3;
	localparam int CFGI_W  = 2;
	localparam int HIDX_W  = 4;   // hidden index, up to 16 units
	localparam int KIDX_W  = 2;   // output index, up to 4 units
	localparam int CIDX_W  = 2;   // class index
	localparam int FPOS_W  = 5;   // feature position carried to the datapath
	localparam int SUM_W   = 40;
	localparam int ACTV_W  = 12;
	localparam int WAIT_W  = 3;

	// Datapath pipeline depth after issue (memory, multiply, ... up to stage 5)
	localparam logic [WAIT_W-1:0] DRAIN_CYC = 3'd5;

	// Input action codes
	localparam logic ACTION_WEIGHT  = 1'b0;
	localparam logic ACTION_FEATURE = 1'b1;

	// Configuration register indexes and reset values
	localparam logic [CFGI_W-1:0] REG_NUM_CLASSES    = 2'd0;
	localparam logic [CFGI_W-1:0] REG_DISTANCE_LIMIT = 2'd1;
	localparam logic [NCLS_W-1:0] NUM_CLASSES_RST    = 3'd4;
	localparam logic [NCLS_W-1:0] NUM_CLASSES_MAX    = 3'd4;
	localparam logic [DIST_W-1:0] DIST_LIMIT_RST     = 24'd409600;
	localparam logic [DIST_W-1:0] DIST_SAT           = 24'hFFFFFF;

	// Sigmoid sampled at -8, -7.5, ..., 8 in Q0.12
	localparam logic [ACTV_W-1:0] SIG_LUT [33] = '{
		12'd1,    12'd2,    12'd4,    12'd6,    12'd10,   12'd17,   12'd27,   12'd45,
		12'd74,   12'd120,  12'd194,  12'd311,  12'd488,  12'd747,  12'd1102, 12'd1546,
		12'd2048, 12'd2550, 12'd2994, 12'd3349, 12'd3608, 12'd3785, 12'd3902, 12'd3976,
		12'd4022, 12'd4051, 12'd4069, 12'd4079, 12'd4086, 12'd4090, 12'd4092, 12'd4094,
		12'd4095
	};

	typedef struct packed {
		logic                    action;
		logic [WIDX_W-1:0]       weight_index;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} in_item_t;

	typedef struct packed {
		logic [CIDX_W-1:0] class_index;
		logic              matched;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_FEAT,
		OP_ACT,
		OP_OBIAS,
		OP_OUTW,
		OP_DIST
	} pipe_op_e_t;

	typedef struct packed {
		pipe_op_e_t        op;
		logic [HIDX_W-1:0] h;
		logic [KIDX_W-1:0] k;
		logic [CIDX_W-1:0] c;
		logic              first;
		logic              fin;
	} pipe_op_t;

	typedef struct packed {
		pipe_op_t          issue;
		logic              wr;
		logic              feat_load;
		logic              ptr_init;
		logic [FPOS_W-1:0] fp;
		logic              res_init;
		logic              res_load;
		logic              clear;
	} ctrl_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FEAT,
		ST_ACT,
		ST_OBIAS,
		ST_OUTW,
		ST_DIST,
		ST_DRAIN,
		ST_RESULT
	} ctrl_state_t;

	// Saturate a 41-bit sum to 40-bit signed
	function automatic logic signed [SUM_W-1:0] sat40(input logic signed [SUM_W:0] v);
		logic signed [SUM_W-1:0] r;
		if (v[SUM_W] != v[SUM_W-1]) begin
			r = {v[SUM_W], {(SUM_W-1){~v[SUM_W]}}};
		end else begin
			r = v[SUM_W-1:0];
		end
		return r;
	endfunction

endpackage

### hdl/mlpci_ctrl.sv
// ----------------------------------------------------------------------------
// mlpci_ctrl
// Sequencer: accepts items, issues datapath operations phase by phase and
// owns the result valid flag and the feature position.
// ----------------------------------------------------------------------------
module mlpci_ctrl #(
	parameter int IN_DIM  = mlpci_pkg::IN_DIM_DEF,
	parameter int HID_DIM = mlpci_pkg::HID_DIM_DEF,
	parameter int OUT_DIM = mlpci_pkg::OUT_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  mlpci_pkg::in_item_t          item,
	output logic                         result_valid,
	input  logic                         result_ready,
	input  logic [mlpci_pkg::NCLS_W-1:0] nc,
	output mlpci_pkg::ctrl_cmd_t         cmd
);
	import mlpci_pkg::*;

	localparam int HIW = (HID_DIM > 1) ? $clog2(HID_DIM) : 1;
	localparam int KW  = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
	localparam int FPW = $clog2(IN_DIM + 1);

	ctrl_state_t          state_q, state_d, after_q, after_d;
	logic [HIW-1:0]       h_q, h_d;
	logic [KW-1:0]        k_q, k_d;
	logic [CIDX_W-1:0]    c_q, c_d;
	logic [WAIT_W-1:0]    wait_cnt_q, wait_cnt_d;
	logic [FPW-1:0]       fp_q, fp_d;
	logic                 last_q, last_d;
	logic                 rv_q, rv_d;
	logic                 h_end, k_end;

	assign h_end        = (h_q == HIW'(HID_DIM - 1));
	assign k_end        = (k_q == KW'(OUT_DIM - 1));
	assign result_valid = rv_q;

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			after_q    <= ST_IDLE;
			h_q        <= '0;
			k_q        <= '0;
			c_q        <= '0;
			wait_cnt_q <= '0;
			fp_q       <= '0;
			last_q     <= 1'b0;
			rv_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			after_q    <= after_d;
			h_q        <= h_d;
			k_q        <= k_d;
			c_q        <= c_d;
			wait_cnt_q <= wait_cnt_d;
			fp_q       <= fp_d;
			last_q     <= last_d;
			rv_q       <= rv_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		after_d    = after_q;
		h_d        = h_q;
		k_d        = k_q;
		c_d        = c_q;
		wait_cnt_d = wait_cnt_q;
		fp_d       = fp_q;
		last_d     = last_q;
		rv_d       = rv_q && !result_ready;
		item_ready = 1'b0;
		cmd        = '0;
		cmd.issue.op = OP_NOP;
		cmd.issue.h  = HIDX_W'(h_q);
		cmd.issue.k  = KIDX_W'(k_q);
		cmd.issue.c  = c_q;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item.action == ACTION_WEIGHT) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.feat_load = 1'b1;
						cmd.ptr_init  = 1'b1;
						cmd.fp        = FPOS_W'(fp_q);
						last_d        = item.last;
						h_d           = '0;
						if (fp_q < FPW'(IN_DIM)) begin
							fp_d    = fp_q + 1'b1;
							state_d = ST_FEAT;
						end else if (item.last) begin
							state_d = ST_ACT;
						end
					end
				end
			end
			ST_FEAT: begin
				// one hidden unit per cycle on the shared MAC
				cmd.issue.op = OP_FEAT;
				h_d = h_q + 1'b1;
				if (h_end) begin
					h_d     = '0;
					state_d = last_q ? ST_ACT : ST_IDLE;
				end
			end
			ST_ACT: begin
				cmd.issue.op = OP_ACT;
				cmd.res_init = (h_q == '0);
				h_d = h_q + 1'b1;
				if (h_end) begin
					h_d        = '0;
					k_d        = '0;
					wait_cnt_d = DRAIN_CYC - 1'b1;
					after_d    = ST_OBIAS;
					state_d    = ST_DRAIN;
				end
			end
			ST_OBIAS: begin
				cmd.issue.op = OP_OBIAS;
				h_d     = '0;
				state_d = ST_OUTW;
			end
			ST_OUTW: begin
				cmd.issue.op  = OP_OUTW;
				cmd.issue.fin = h_end;
				h_d = h_q + 1'b1;
				if (h_end) begin
					h_d = '0;
					if (k_end) begin
						k_d        = '0;
						c_d        = '0;
						wait_cnt_d = DRAIN_CYC - 1'b1;
						after_d    = (nc == '0) ? ST_RESULT : ST_DIST;
						state_d    = ST_DRAIN;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = ST_OBIAS;
					end
				end
			end
			ST_DIST: begin
				cmd.issue.op    = OP_DIST;
				cmd.issue.first = (k_q == '0);
				cmd.issue.fin   = k_end;
				k_d = k_q + 1'b1;
				if (k_end) begin
					k_d = '0;
					if ((NCLS_W'(c_q) + 1'b1) == nc) begin
						wait_cnt_d = DRAIN_CYC - 1'b1;
						after_d    = ST_RESULT;
						state_d    = ST_DRAIN;
					end else begin
						c_d = c_q + 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				if (wait_cnt_q == '0) begin
					state_d = after_q;
				end else begin
					wait_cnt_d = wait_cnt_q - 1'b1;
				end
			end
			ST_RESULT: begin
				// load only into a free output slot
				if (!rv_q || result_ready) begin
					cmd.res_load = 1'b1;
					cmd.clear    = 1'b1;
					rv_d         = 1'b1;
					fp_d         = '0;
					last_d       = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/mlpci_dpath.sv
// ----------------------------------------------------------------------------
// mlpci_dpath
// Weight store, hidden sums, sigmoid, output layer and distance search.
// Operations flow through a five-stage pipeline tagged with their command.
// ----------------------------------------------------------------------------
module mlpci_dpath #(
	parameter int IN_DIM       = mlpci_pkg::IN_DIM_DEF,
	parameter int HID_DIM      = mlpci_pkg::HID_DIM_DEF,
	parameter int OUT_DIM      = mlpci_pkg::OUT_DIM_DEF,
	parameter int WEIGHT_DEPTH = mlpci_pkg::WEIGHT_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mlpci_pkg::ctrl_cmd_t         cmd,
	input  mlpci_pkg::in_item_t          item,
	input  logic [mlpci_pkg::DIST_W-1:0] limit,
	output mlpci_pkg::out_item_t         result
);
	import mlpci_pkg::*;

	localparam int AW   = $clog2(WEIGHT_DEPTH);
	localparam int HIW  = (HID_DIM > 1) ? $clog2(HID_DIM) : 1;
	localparam int KW   = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
	localparam int W2_A = (HID_DIM * IN_DIM) % WEIGHT_DEPTH;
	localparam int HB_A = (HID_DIM * IN_DIM + OUT_DIM * HID_DIM) % WEIGHT_DEPTH;
	localparam int OB_A = (HID_DIM * IN_DIM + OUT_DIM * HID_DIM + HID_DIM) % WEIGHT_DEPTH;
	localparam int WXW  = AW + WIDX_W;

	// Step a store pointer with wrap at the store depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [AW:0] s);
		logic [AW:0] t;
		t = {1'b0, p} + s;
		if (t >= (AW+1)'(WEIGHT_DEPTH)) begin
			t = t - (AW+1)'(WEIGHT_DEPTH);
		end
		return t[AW-1:0];
	endfunction

	logic [VAL_W-1:0]         mem [WEIGHT_DEPTH];
	logic [AW-1:0]            hw_q, hb_q, ob_q, w2_q, rd_addr;
	logic [WXW-1:0]           wi_ext;
	logic                     wr_ok;
	logic signed [VAL_W-1:0]  feat_q;
	logic signed [VAL_W-1:0]  rdata_s1, w_s2;
	pipe_op_t                 op_s1, op_s2, op_s3, op_s4, op_s5;

	logic signed [SUM_W-1:0]  sums [HID_DIM];
	logic [ACTV_W-1:0]        act [HID_DIM];
	logic signed [SUM_W-1:0]  outs [OUT_DIM];
	logic signed [SUM_W:0]    acc_q, acc_nx;

	logic signed [VAL_W:0]    mul_a;
	logic signed [2*VAL_W:0]  prod_s2;
	logic [1:0]               csh;
	logic signed [SUM_W:0]    err;
	logic [SUM_W:0]           absv;
	logic [17:0]              mag_s2;
	logic                     big_s2, big_s3;
	logic [35:0]              sq_s3;
	logic signed [SUM_W-1:0]  sum_rd, net_s3;
	logic signed [SUM_W:0]    u_sum;
	logic [5:0]               ti;
	logic [ACTV_W-1:0]        lo_c, lo_s4, lo_s5;
	logic [8:0]               diff_c, diff_s4;
	logic [10:0]              f_c, f_s4;
	logic [19:0]              sp_s5;
	logic [20:0]              rnd;
	logic [DIST_W-1:0]        dist_q, dprev, dnew, best_q;
	logic [DIST_W:0]          dsum;
	logic [CIDX_W-1:0]        bidx_q;
	logic                     matched_q;

	// Weight writes, gated by the store depth
	assign wi_ext = WXW'(item.weight_index);
	assign wr_ok  = cmd.wr && (wi_ext < WXW'(WEIGHT_DEPTH));

	always_comb begin
		case (cmd.issue.op)
			OP_ACT:   rd_addr = hb_q;
			OP_OBIAS: rd_addr = ob_q;
			OP_OUTW:  rd_addr = w2_q;
			default:  rd_addr = hw_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wi_ext[AW-1:0]] <= item.value;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// Address pointers and feature latch
	always_ff @(posedge clk) begin
		if (cmd.feat_load) begin
			feat_q <= item.value;
		end
		if (cmd.ptr_init) begin
			hw_q <= AW'(cmd.fp);
			hb_q <= AW'(HB_A);
			ob_q <= AW'(OB_A);
			w2_q <= AW'(W2_A);
		end else begin
			case (cmd.issue.op)
				OP_FEAT:  hw_q <= wrap_add(hw_q, (AW+1)'(IN_DIM));
				OP_ACT:   hb_q <= wrap_add(hb_q, (AW+1)'(1));
				OP_OBIAS: ob_q <= wrap_add(ob_q, (AW+1)'(1));
				OP_OUTW:  w2_q <= wrap_add(w2_q, (AW+1)'(1));
				default: ;
			endcase
		end
	end

	// Operation tags follow their data down the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
			op_s3 <= '0;
			op_s4 <= '0;
			op_s5 <= '0;
		end else begin
			op_s1 <= cmd.issue;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
			op_s4 <= op_s3;
			op_s5 <= op_s4;
		end
	end

	// Stage 1: shared multiply, distance magnitude
	always_comb begin
		if (op_s1.op == OP_OUTW) begin
			mul_a = signed'({5'b0, act[op_s1.h[HIW-1:0]]});
		end else begin
			mul_a = (VAL_W+1)'(feat_q);
		end
		csh  = op_s1.c >> op_s1.k;
		err  = (SUM_W+1)'(outs[op_s1.k[KW-1:0]]) -
			(csh[0] ? (SUM_W+1)'(41'sd16777216) : (SUM_W+1)'(41'sd0));
		absv = err[SUM_W] ? (-err) : err;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * rdata_s1;
		w_s2    <= rdata_s1;
		mag_s2  <= absv[29:12];
		big_s2  <= |absv[SUM_W:30];
	end

	// Stage 2: hidden accumulate, net input, output layer, square
	assign sum_rd = sums[op_s2.h[HIW-1:0]];
	assign acc_nx = acc_q + (SUM_W+1)'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HID_DIM; i++) begin
				sums[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < HID_DIM; i++) begin
				sums[i] <= '0;
			end
		end else if (op_s2.op == OP_FEAT) begin
			sums[op_s2.h[HIW-1:0]] <= sat40((SUM_W+1)'(sum_rd) + (SUM_W+1)'(prod_s2));
		end
	end

	always_ff @(posedge clk) begin
		net_s3 <= sat40((SUM_W+1)'(sum_rd) + ((SUM_W+1)'(w_s2) <<< 12));
		sq_s3  <= mag_s2 * mag_s2;
		big_s3 <= big_s2;
		if (op_s2.op == OP_OBIAS) begin
			acc_q <= (SUM_W+1)'(w_s2) <<< 12;
		end else if (op_s2.op == OP_OUTW) begin
			acc_q <= acc_nx;
			if (op_s2.fin) begin
				outs[op_s2.k[KW-1:0]] <= sat40(acc_nx);
			end
		end
	end

	// Stage 3: sigmoid segment lookup
	always_comb begin
		u_sum  = (SUM_W+1)'(net_s3) + (SUM_W+1)'(41'sd134217728);
		ti     = {1'b0, u_sum[27:23]};
		f_c    = u_sum[22:12];
		lo_c   = SIG_LUT[ti];
		diff_c = 9'(SIG_LUT[ti + 6'd1] - SIG_LUT[ti]);
		if (net_s3 >= 40'sd134217728) begin
			lo_c   = SIG_LUT[32];
			diff_c = '0;
		end else if (net_s3 < -40'sd134217728) begin
			lo_c   = SIG_LUT[0];
			diff_c = '0;
		end
	end

	// Stage 3: class distance, saturating
	always_comb begin
		dprev = op_s3.first ? '0 : dist_q;
		dsum  = {1'b0, dprev} + {1'b0, sq_s3[35:12]};
		if (big_s3 || dsum[DIST_W]) begin
			dnew = DIST_SAT;
		end else begin
			dnew = dsum[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		lo_s4   <= lo_c;
		diff_s4 <= diff_c;
		f_s4    <= f_c;
		if (cmd.res_init) begin
			best_q    <= limit;
			bidx_q    <= '0;
			matched_q <= 1'b0;
		end else if (op_s3.op == OP_DIST) begin
			dist_q <= dnew;
			if (op_s3.fin && (dnew < best_q)) begin
				best_q    <= dnew;
				bidx_q    <= op_s3.c;
				matched_q <= 1'b1;
			end
		end
	end

	// Stages 4 and 5: interpolate and store the activation
	assign rnd = 21'(sp_s5) + 21'd1024;

	always_ff @(posedge clk) begin
		sp_s5 <= diff_s4 * f_s4;
		lo_s5 <= lo_s4;
		if (op_s5.op == OP_ACT) begin
			act[op_s5.h[HIW-1:0]] <= lo_s5 + ACTV_W'(rnd[20:11]);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			result.class_index <= bidx_q;
			result.matched     <= matched_q;
		end
	end

endmodule

### hdl/mlp_classifier_inference.sv
// ----------------------------------------------------------------------------
// mlp_classifier_inference
// Two-layer perceptron classifier with table sigmoid and nearest binary code.
// ----------------------------------------------------------------------------
// A weight item writes the store. A feature item takes one multiply-accumulate
// per hidden unit on the shared MAC.
// The last feature then runs activations, output layer and distance search
// (no distance search when num_classes is zero), then loads the result.
// Reset clears control, operation tags, hidden sums and configuration; the
// weight store is undefined until written and gets no clearing pass.
module mlp_classifier_inference #(
	parameter int IN_DIM       = mlpci_pkg::IN_DIM_DEF,
	parameter int HID_DIM      = mlpci_pkg::HID_DIM_DEF,
	parameter int OUT_DIM      = mlpci_pkg::OUT_DIM_DEF,
	parameter int WEIGHT_DEPTH = mlpci_pkg::WEIGHT_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  mlpci_pkg::in_item_t          item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output mlpci_pkg::out_item_t         result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mlpci_pkg::CFGI_W-1:0] cfg_index,
	input  logic [mlpci_pkg::DIST_W-1:0] cfg_data
);
	import mlpci_pkg::*;

	logic [NCLS_W-1:0] num_classes_q, nc_eff;
	logic [DIST_W-1:0] distance_limit_q;
	ctrl_cmd_t         cmd;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q    <= NUM_CLASSES_RST;
			distance_limit_q <= DIST_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NUM_CLASSES:    num_classes_q    <= cfg_data[NCLS_W-1:0];
				REG_DISTANCE_LIMIT: distance_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the class count to the code space
	assign nc_eff = (num_classes_q > NUM_CLASSES_MAX) ? NUM_CLASSES_MAX : num_classes_q;

	mlpci_ctrl #(
		.IN_DIM  (IN_DIM),
		.HID_DIM (HID_DIM),
		.OUT_DIM (OUT_DIM)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.nc           (nc_eff),
		.cmd          (cmd)
	);

	mlpci_dpath #(
		.IN_DIM       (IN_DIM),
		.HID_DIM      (HID_DIM),
		.OUT_DIM      (OUT_DIM),
		.WEIGHT_DEPTH (WEIGHT_DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.limit  (distance_limit_q),
		.result (result)
	);

	// No match always reports class zero
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.matched) |-> (result.class_index == '0))
		else $error("unmatched result carries a class index");

	// A new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!result_valid || result_ready))
		else $error("result overwritten before it was taken");

	// Store writes only on an accepted weight item
	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (item_valid && item_ready && (item.action == ACTION_WEIGHT)))
		else $error("weight write without an accepted weight item");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-layer perceptron classifier. Loads the
// weight store, streams samples under several register settings, and checks
// every class result against a built-in fixed-point prediction.
// ----------------------------------------------------------------------------
module testbench;
	import mlpci_pkg::*;

	localparam int N_IN      = 12;
	localparam int N_HID     = 7;
	localparam int N_OUT     = 2;
	localparam int N_WORDS   = 128;
	localparam int OW_BASE   = N_HID * N_IN;
	localparam int HB_BASE   = OW_BASE + N_OUT * N_HID;
	localparam int OB_BASE   = HB_BASE + N_HID;
	localparam int SETTLE    = 120;
	localparam int WDOG_MAX  = 4000;
	localparam longint MAX40 = 64'sd549755813887;
	localparam longint MIN40 = -64'sd549755813888;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFGI_W-1:0] cfg_index = '0;
	logic [DIST_W-1:0] cfg_data = '0;

	// Predictor state
	logic signed [VAL_W-1:0] weight_mem [N_WORDS];
	longint hidden_acc [N_HID];
	int feat_pos;
	int class_count;
	logic [DIST_W-1:0] dist_limit;
	out_item_t class_q[$];

	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int matches_seen = 0;
	int rx_hold = 0;
	bit no_idle = 0;
	int idle_cycles = 0;

	const int sig_lut [33] = '{1, 2, 4, 6, 10, 17, 27, 45, 74, 120, 194, 311, 488, 747,
		1102, 1546, 2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022, 4051, 4069,
		4079, 4086, 4090, 4092, 4094, 4095};

	mlp_classifier_inference dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clip40(longint v);
		if (v > MAX40) return MAX40;
		if (v < MIN40) return MIN40;
		return v;
	endfunction

	function automatic int sigmoid_q12(longint net);
		longint u;
		int idx, frac, lo, hi;
		if (net >= (64'sd1 <<< 27)) return sig_lut[32];
		if (net < -(64'sd1 <<< 27)) return sig_lut[0];
		u = (net + (64'sd1 <<< 27)) >>> 12;
		idx = int'(u >>> 11) & 31;
		frac = int'(u) & 2047;
		lo = sig_lut[idx];
		hi = sig_lut[idx + 1];
		return lo + (((hi - lo) * frac + 1024) >>> 11);
	endfunction

	// Advance the classifier by one item; return 1 when it yields a class
	function automatic bit classify_step(in_item_t it, output out_item_t res);
		int act [N_HID];
		longint outs [N_OUT];
		longint s, e, mag, dsq, tgt;
		longint best;
		int nc;
		res = '0;
		if (it.action == ACTION_WEIGHT) begin
			weight_mem[it.weight_index] = it.value;
			return 0;
		end
		if (feat_pos < N_IN) begin
			for (int h = 0; h < N_HID; h++)
				hidden_acc[h] = clip40(hidden_acc[h]
					+ longint'(weight_mem[h * N_IN + feat_pos]) * longint'($signed(it.value)));
			feat_pos++;
		end
		if (!it.last) return 0;
		for (int h = 0; h < N_HID; h++)
			act[h] = sigmoid_q12(clip40(hidden_acc[h] + longint'(weight_mem[HB_BASE + h]) * 4096));
		for (int k = 0; k < N_OUT; k++) begin
			s = longint'(weight_mem[OB_BASE + k]) * 4096;
			for (int h = 0; h < N_HID; h++)
				s += longint'(act[h]) * longint'(weight_mem[OW_BASE + k * N_HID + h]);
			outs[k] = clip40(s);
		end
		nc = (class_count > 4) ? 4 : class_count;
		best = longint'(dist_limit);
		for (int c = 0; c < nc; c++) begin
			dsq = 0;
			for (int k = 0; k < N_OUT; k++) begin
				tgt = ((c >> k) & 1) ? (64'sd1 <<< 24) : 0;
				e = outs[k] - tgt;
				mag = (e < 0 ? -e : e) >>> 12;
				if (mag >= (64'sd1 <<< 18)) begin
					dsq = 24'hFFFFFF;
					continue;
				end
				dsq += (mag * mag) >>> 12;
				if (dsq > 24'hFFFFFF) dsq = 24'hFFFFFF;
			end
			if (dsq < best) begin
				best = dsq;
				res.class_index = CIDX_W'(c);
				res.matched = 1'b1;
			end
		end
		for (int h = 0; h < N_HID; h++) hidden_acc[h] = 0;
		feat_pos = 0;
		return 1;
	endfunction

	// Offer one item after a random gap; hold valid until it is taken
	task automatic send_item(in_item_t it);
		int gap;
		out_item_t res;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
		if (classify_step(it, res)) class_q.push_back(res);
	endtask

	task automatic send_weight(int idx, logic [15:0] w);
		in_item_t it;
		it.action = ACTION_WEIGHT;
		it.weight_index = WIDX_W'(idx);
		it.value = w;
		it.last = $urandom_range(0, 1);
		send_item(it);
	endtask

	task automatic send_feature(logic [15:0] v, bit lst);
		in_item_t it;
		it.action = ACTION_FEATURE;
		it.weight_index = WIDX_W'($urandom);
		it.value = v;
		it.last = lst;
		send_item(it);
	endtask

	// Full sample of n features, the last one flagged
	task automatic send_sample(int n);
		for (int i = 0; i < n; i++) send_feature(16'($urandom), i == n - 1);
	endtask

	// Wait for all classes to drain, then write one register
	task automatic write_reg(logic [CFGI_W-1:0] idx, logic [DIST_W-1:0] data);
		item_valid <= 1'b0;
		@(posedge clk);
		while (class_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_NUM_CLASSES) class_count = int'(data[NCLS_W-1:0]);
		else if (idx == REG_DISTANCE_LIMIT) dist_limit = data;
		@(posedge clk);
	endtask

	// Output-layer weights and biases near unit scale keep class distances within reach
	function automatic logic [15:0] pick_weight(int idx, bit gentle);
		if (gentle && idx >= OW_BASE) return 16'($signed($urandom_range(0, 8192)) - 4096);
		return 16'($urandom);
	endfunction

	task automatic load_store(bit gentle);
		for (int i = 0; i < N_WORDS; i++) send_weight(i, pick_weight(i, gentle));
	endtask

	task automatic test_store_extremes();
		for (int i = 0; i < N_WORDS; i++)
			send_weight(i, (i % 3 == 0) ? 16'h7FFF : (i % 3 == 1) ? 16'h8000 : 16'($urandom));
		send_sample(N_IN);
		for (int i = 0; i < N_IN; i++) send_feature(16'h7FFF, i == N_IN - 1);
		for (int i = 0; i < N_IN; i++) send_feature(16'h8000, i == N_IN - 1);
		load_store(1);
	endtask

	task automatic test_sample_shapes();
		// too few features, single feature, zero feature
		send_sample(1);
		send_feature(16'h0000, 1);
		send_sample(5);
		// too many features: extra ones are ignored
		send_sample(N_IN + 4);
		// weight write inside a sample
		send_feature(16'($urandom), 0);
		send_weight(OW_BASE + 3, 16'h1000);
		send_feature(16'($urandom), 0);
		send_weight(OB_BASE, 16'hF000);
		send_feature(16'($urandom), 1);
	endtask

	task automatic test_register_sweep();
		logic [NCLS_W-1:0] ncls [5] = '{3'd0, 3'd1, 3'd7, 3'd5, 3'd4};
		logic [DIST_W-1:0] lims [4] = '{24'd0, 24'hFFFFFF, 24'd4096, DIST_LIMIT_RST};
		for (int i = 0; i < 5; i++) begin
			write_reg(REG_NUM_CLASSES, DIST_W'(ncls[i]));
			for (int j = 0; j < 4; j++) begin
				write_reg(REG_DISTANCE_LIMIT, lims[j]);
				send_sample(N_IN);
				send_sample($urandom_range(1, N_IN));
			end
		end
	endtask

	task automatic test_random_traffic(int budget);
		int start;
		start = items_sent;
		while (items_sent - start < budget) begin
			if ($urandom_range(0, 99) < 4) begin
				write_reg(REG_NUM_CLASSES, DIST_W'($urandom_range(1, 4)));
				write_reg(REG_DISTANCE_LIMIT, ($urandom_range(0, 3) == 0) ?
					DIST_W'($urandom) : DIST_W'($urandom_range(0, 800000)));
				no_idle = ($urandom_range(0, 3) == 0);
			end
			case ($urandom_range(0, 9))
				0: send_weight($urandom_range(0, N_WORDS - 1), pick_weight(
					$urandom_range(0, N_WORDS - 1), 1));
				1: send_sample($urandom_range(1, N_IN + 3));
				2: send_weight($urandom_range(OW_BASE, N_WORDS - 1), 16'($urandom));
				default: send_sample(N_IN);
			endcase
		end
		no_idle = 0;
	endtask

	task automatic test_backpressure();
		rx_hold = 500;
		no_idle = 1;
		for (int i = 0; i < 6; i++) send_sample(2);
		no_idle = 0;
	endtask

	// Result receiver: random stalls, plus one long hold when asked
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				result_ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else begin
				w = no_idle ? 0 : $urandom_range(0, 6);
				if (w > 0) begin
					result_ready <= 1'b0;
					repeat (w) @(posedge clk);
				end
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	// Compare each class result with the oldest prediction
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (class_q.size() == 0) begin
				$error("unexpected result class_index=%0d matched=%0d",
					result.class_index, result.matched);
				fail_count++;
			end else begin
				exp_r = class_q.pop_front();
				if (exp_r.matched) matches_seen++;
				if (result.class_index !== exp_r.class_index) begin
					$error("class_index expected %0d actual %0d",
						exp_r.class_index, result.class_index);
					fail_count++;
				end
				if (result.matched !== exp_r.matched) begin
					$error("matched expected %0d actual %0d", exp_r.matched, result.matched);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: stop when nothing moves for too long
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_MAX) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int h = 0; h < N_HID; h++) hidden_acc[h] = 0;
		feat_pos = 0;
		class_count = int'(NUM_CLASSES_RST);
		dist_limit = DIST_LIMIT_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_store_extremes();
		test_sample_shapes();
		test_register_sweep();
		test_backpressure();
		write_reg(REG_NUM_CLASSES, DIST_W'(NUM_CLASSES_RST));
		write_reg(REG_DISTANCE_LIMIT, DIST_LIMIT_RST);
		test_random_traffic(1150);
		item_valid <= 1'b0;
		while (class_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d items, %0d class results (%0d matched)",
			items_sent, results_seen, matches_seen);
		$display("store extremes, short and long samples, register sweep, output stall");
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
